>>> rtl/ade_pkg.sv
// Shared types and constants for the percussive attack/decay envelope block.
package ade_pkg;

    localparam int PHASE_W = 2;
    localparam int CFG_INDEX_W = 2;

    // Envelope phase codes as they appear on the result channel
    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE   = 2'd0,
        PH_ATTACK = 2'd1,
        PH_DECAY  = 2'd2
    } phase_t;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_STEP  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_STEP   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_FACTOR = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic prep;
        logic mult;
        logic commit;
    } ade_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic slot_free;
    } ade_status_t;

endpackage

>>> rtl/ade_in_if.sv
// Input channel: one gate/trigger sample per item.
interface ade_in_if;
    logic valid;
    logic ready;
    logic gate_open;
    logic trigger_high;

    modport source (output valid, output gate_open, output trigger_high, input ready);
    modport sink (input valid, input gate_open, input trigger_high, output ready);
endinterface

>>> rtl/ade_out_if.sv
// Output channel: one envelope level and phase per item.
interface ade_out_if
    import ade_pkg::*;
#(
    parameter int LEVEL_W = 24
);
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level_out;
    logic [PHASE_W-1:0] phase_out;

    modport source (output valid, output level_out, output phase_out, input ready);
    modport sink (input valid, input level_out, input phase_out, output ready);
endinterface

>>> rtl/ade_ctrl.sv
// Sequencing controller: accept, operand setup, multiply, commit.
module ade_ctrl
    import ade_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ade_status_t status,
    output ade_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready_reg)
                    begin
                        state_reg    <= S_PREP;
                        in_ready_reg <= 1'b0;
                    end
                end
                S_PREP:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // hold until the output register can take the item
                    if (status.slot_free)
                    begin
                        state_reg    <= S_IDLE;
                        in_ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg    <= S_IDLE;
                    in_ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign in_ready = in_ready_reg;

    always_comb
    begin
        cmd.capture = (state_reg == S_IDLE) && in_valid && in_ready_reg;
        cmd.prep    = (state_reg == S_PREP);
        cmd.mult    = (state_reg == S_MUL);
        cmd.commit  = (state_reg == S_DONE) && status.slot_free;
    end

`ifndef ASSERT_OFF
    a_capture_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_PREP) && !in_ready_reg)
        else $error("controller did not go busy after accepting an item");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready_reg |-> (state_reg == S_IDLE))
        else $error("ready raised while an item is in flight");

    a_commit_release: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> in_ready_reg && !cmd.commit)
        else $error("controller did not release after commit");
`endif

endmodule

>>> rtl/ade_dp.sv
// Envelope datapath: state, configuration, shared multiplier, output register.
module ade_dp
    import ade_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = 23,
    parameter int STEP_FRAC_BITS  = 24
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [STEP_FRAC_BITS:0]  cfg_data,
    input  logic                     gate_open,
    input  logic                     trigger_high,
    input  ade_cmd_t                 cmd,
    output ade_status_t              status,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [LEVEL_FRAC_BITS:0] level_out,
    output logic [PHASE_W-1:0]       phase_out
);

    localparam int LEVEL_W = LEVEL_FRAC_BITS + 1;
    localparam int STEP_W  = STEP_FRAC_BITS + 1;
    localparam int PROD_W  = LEVEL_W + STEP_W;
    localparam logic [STEP_W-1:0]  ONE_STEP   = STEP_W'(1) << STEP_FRAC_BITS;
    localparam logic [STEP_W-1:0]  STEP_MAX   = '1;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(1) << LEVEL_FRAC_BITS;

    // configuration
    logic [STEP_W-1:0]         attack_step_reg;
    logic [STEP_W-1:0]         decay_step_reg;
    logic [STEP_FRAC_BITS-1:0] decay_factor_reg;

    // envelope state
    phase_t             phase_reg;
    logic [STEP_W-1:0]  elapsed_reg;
    logic [LEVEL_W-1:0] start_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               prev_gate_reg;
    logic               prev_trig_reg;

    // item in flight
    logic               gate_reg;
    logic               trig_reg;
    phase_t             phase_p_reg;
    logic [STEP_W-1:0]  elapsed_p_reg;
    logic [LEVEL_W-1:0] start_p_reg;
    logic               end_p_reg;
    logic [STEP_W-1:0]  op_a_reg;
    logic [LEVEL_W-1:0] op_b_reg;
    logic [PROD_W-1:0]  prod_reg;

    // output register
    logic               out_valid_reg;
    logic [LEVEL_W-1:0] level_out_reg;
    phase_t             phase_out_reg;

    // operand setup
    logic               restart;
    phase_t             ph_start;
    logic [STEP_W-1:0]  e_start;
    logic [LEVEL_W-1:0] start_sel;
    logic [LEVEL_W-1:0] span;
    logic [STEP_W-1:0]  step_sel;
    logic [STEP_W:0]    step_sum;
    logic [STEP_W-1:0]  e_sat;
    logic               end_flag;
    logic [STEP_W-1:0]  op_a;
    logic [LEVEL_W-1:0] op_b;
    logic [STEP_W-1:0]  elapsed_p;

    // commit
    logic [LEVEL_W-1:0] prod_sh;
    phase_t             phase_next;
    logic [STEP_W-1:0]  elapsed_next;
    logic [LEVEL_W-1:0] level_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_step_reg  <= ONE_STEP;
            decay_step_reg   <= ONE_STEP;
            decay_factor_reg <= '1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ATTACK_STEP:  attack_step_reg  <= cfg_data;
                REG_DECAY_STEP:   decay_step_reg   <= cfg_data;
                REG_DECAY_FACTOR: decay_factor_reg <= cfg_data[STEP_FRAC_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        restart   = (trig_reg && !prev_trig_reg) || (gate_reg && !prev_gate_reg);
        ph_start  = restart ? PH_ATTACK : phase_reg;
        e_start   = restart ? '0 : elapsed_reg;
        start_sel = (e_start == '0) ? level_reg : start_reg;
        span      = (FULL_LEVEL >= start_sel) ? FULL_LEVEL - start_sel : '0;
        step_sel  = (ph_start == PH_DECAY) ? decay_step_reg : attack_step_reg;
        step_sum  = {1'b0, e_start} + {1'b0, step_sel};
        // saturate the elapsed count at its maximum
        e_sat     = step_sum[STEP_W] ? STEP_MAX : step_sum[STEP_W-1:0];
        end_flag  = step_sel[STEP_W-1] || (e_sat > ONE_STEP);
        case (ph_start)
            PH_ATTACK:
            begin
                op_a      = e_sat;
                op_b      = span;
                elapsed_p = e_sat;
            end
            PH_DECAY:
            begin
                op_a      = {1'b0, decay_factor_reg};
                op_b      = level_reg;
                elapsed_p = e_sat;
            end
            default:
            begin
                op_a      = '0;
                op_b      = '0;
                elapsed_p = e_start;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            gate_reg <= gate_open;
            trig_reg <= trigger_high;
        end
        if (cmd.prep)
        begin
            phase_p_reg   <= ph_start;
            elapsed_p_reg <= elapsed_p;
            start_p_reg   <= start_sel;
            end_p_reg     <= end_flag;
            op_a_reg      <= op_a;
            op_b_reg      <= op_b;
        end
        if (cmd.mult)
        begin
            prod_reg <= PROD_W'(op_a_reg) * PROD_W'(op_b_reg);
        end
    end

    assign prod_sh = prod_reg[STEP_FRAC_BITS +: LEVEL_W];

    always_comb
    begin
        case (phase_p_reg)
            PH_ATTACK:
            begin
                if (end_p_reg)
                begin
                    phase_next   = PH_DECAY;
                    level_next   = FULL_LEVEL;
                    elapsed_next = '0;
                end
                else
                begin
                    phase_next   = PH_ATTACK;
                    level_next   = start_p_reg + prod_sh;
                    elapsed_next = elapsed_p_reg;
                end
            end
            PH_DECAY:
            begin
                if (end_p_reg)
                begin
                    phase_next   = PH_IDLE;
                    level_next   = '0;
                    elapsed_next = '0;
                end
                else
                begin
                    phase_next   = PH_DECAY;
                    level_next   = prod_sh;
                    elapsed_next = elapsed_p_reg;
                end
            end
            default:
            begin
                phase_next   = PH_IDLE;
                level_next   = '0;
                elapsed_next = elapsed_p_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            elapsed_reg   <= '0;
            start_reg     <= '0;
            level_reg     <= '0;
            prev_gate_reg <= 1'b0;
            prev_trig_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                phase_reg     <= phase_next;
                elapsed_reg   <= elapsed_next;
                start_reg     <= start_p_reg;
                level_reg     <= level_next;
                prev_gate_reg <= gate_reg;
                prev_trig_reg <= trig_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            level_out_reg <= level_next;
            phase_out_reg <= phase_next;
        end
    end

    assign status.slot_free = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign level_out        = level_out_reg;
    assign phase_out        = phase_out_reg;

`ifndef ASSERT_OFF
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg && (level_out_reg == level_reg)
                       && (phase_out_reg == phase_reg))
        else $error("committed item does not match envelope state");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= FULL_LEVEL)
        else $error("envelope level above full scale");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (level_reg == '0))
        else $error("idle phase with nonzero level");
`endif

endmodule

>>> rtl/percussive_ad_envelope_top.sv
// Top level of the percussive attack/decay envelope generator.
// Each input item is one audio sample of gate and trigger bits and yields one
// item of envelope level (Q1.LEVEL_FRAC_BITS) and phase. An item passes through
// capture at acceptance, operand setup, one pass through the single shared
// multiplier (attack ramp or decay product), and commit, in that order. Commit
// writes the result into the output register and raises input ready together,
// so no new item is accepted before the last one is committed. Commit waits while
// the previous result still sits untaken in the output register. Input ready is low
// while an item is in flight. Reset clears the envelope state and output valid
// and loads the default configuration, with no clearing pass. Configuration
// registers are to be written while no item is in flight; this is not enforced.
module percussive_ad_envelope_top
    import ade_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = 23,
    parameter int STEP_FRAC_BITS  = 24
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [STEP_FRAC_BITS:0] cfg_data,
    ade_in_if.sink                  in_ch,
    ade_out_if.source               out_ch
);

    ade_cmd_t    cmd;
    ade_status_t status;

    ade_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    ade_dp #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS),
        .STEP_FRAC_BITS  (STEP_FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .gate_open    (in_ch.gate_open),
        .trigger_high (in_ch.trigger_high),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .level_out    (out_ch.level_out),
        .phase_out    (out_ch.phase_out)
    );

endmodule

>>> test/percussive_ad_envelope_top_tb.sv
// Self-checking testbench for the percussive attack/decay envelope generator.
module percussive_ad_envelope_top_tb;
    import ade_pkg::*;

    localparam int LEVEL_FRAC_BITS = 23;
    localparam int STEP_FRAC_BITS  = 24;
    localparam int LEVEL_W = LEVEL_FRAC_BITS + 1;
    localparam int STEP_W  = STEP_FRAC_BITS + 1;

    localparam logic [63:0] ONE_STEP   = 64'd1 << STEP_FRAC_BITS;
    localparam logic [63:0] STEP_MAX   = (ONE_STEP << 1) - 64'd1;
    localparam logic [63:0] FACTOR_MAX = ONE_STEP - 64'd1;
    localparam logic [63:0] FULL_LEVEL = 64'd1 << LEVEL_FRAC_BITS;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS  = 1900;
    localparam int HOLD_AT       = 400;
    localparam int LONG_HOLD     = 300;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PRINT_LIMIT   = 40;

    typedef struct packed {
        logic gate;
        logic trig;
    } sample_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        phase_t             ph;
    } env_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [STEP_W-1:0]      cfg_data = '0;

    logic in_valid = 1'b0;
    logic in_gate = 1'b0;
    logic in_trig = 1'b0;
    logic out_ready = 1'b0;

    ade_in_if in_ch ();
    ade_out_if #(.LEVEL_W(LEVEL_W)) out_ch ();

    assign in_ch.valid        = in_valid;
    assign in_ch.gate_open    = in_gate;
    assign in_ch.trigger_high = in_trig;
    assign out_ch.ready       = out_ready;

    percussive_ad_envelope_top #(
        .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS),
        .STEP_FRAC_BITS(STEP_FRAC_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    // Register copies, written alongside the block's own registers
    logic [STEP_W-1:0]   cfg_attack_step  = ONE_STEP[STEP_W-1:0];
    logic [STEP_W-1:0]   cfg_decay_step   = ONE_STEP[STEP_W-1:0];
    logic [STEP_W-2:0]   cfg_decay_factor = FACTOR_MAX[STEP_W-2:0];

    // Envelope state
    phase_t             env_phase     = PH_IDLE;
    logic [STEP_W-1:0]  env_elapsed   = '0;
    logic [LEVEL_W-1:0] env_start     = '0;
    logic [LEVEL_W-1:0] env_level     = '0;
    logic               env_prev_gate = 1'b0;
    logic               env_prev_trig = 1'b0;

    sample_t sample_queue[$];
    env_t    expected_env[$];

    int queued_items   = 0;
    int mismatch_count = 0;
    int results_seen   = 0;
    int in_gap         = 0;
    int in_gap_max     = 0;
    int out_wait       = 0;
    int out_gap_max    = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    logic long_hold_done = 1'b0;

    logic gen_gate = 1'b0;
    logic gen_trig = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic advance_envelope(input logic gate, input logic trig, output env_t res);
        logic [63:0] sum;
        logic [63:0] span;
        logic [63:0] prod;
        if ((trig && !env_prev_trig) || (gate && !env_prev_gate))
        begin
            env_phase   = PH_ATTACK;
            env_elapsed = '0;
        end
        // Capture the level the ramp starts from
        if (env_elapsed == '0)
            env_start = env_level;
        if (env_phase == PH_ATTACK)
        begin
            sum = 64'(env_elapsed) + 64'(cfg_attack_step);
            env_elapsed = (sum > STEP_MAX) ? STEP_MAX[STEP_W-1:0] : sum[STEP_W-1:0];
            if (64'(cfg_attack_step) >= ONE_STEP || 64'(env_elapsed) > ONE_STEP)
            begin
                env_phase   = PH_DECAY;
                env_level   = FULL_LEVEL[LEVEL_W-1:0];
                env_elapsed = '0;
            end
            else
            begin
                span = (FULL_LEVEL >= 64'(env_start)) ? FULL_LEVEL - 64'(env_start) : 64'd0;
                prod = (64'(env_elapsed) * span) >> STEP_FRAC_BITS;
                sum  = 64'(env_start) + prod;
                env_level = sum[LEVEL_W-1:0];
            end
        end
        else if (env_phase == PH_DECAY)
        begin
            sum = 64'(env_elapsed) + 64'(cfg_decay_step);
            env_elapsed = (sum > STEP_MAX) ? STEP_MAX[STEP_W-1:0] : sum[STEP_W-1:0];
            if (64'(cfg_decay_step) >= ONE_STEP || 64'(env_elapsed) > ONE_STEP)
            begin
                env_phase   = PH_IDLE;
                env_level   = '0;
                env_elapsed = '0;
            end
            else
            begin
                prod = (64'(env_level) * 64'(cfg_decay_factor)) >> STEP_FRAC_BITS;
                env_level = prod[LEVEL_W-1:0];
            end
        end
        else
        begin
            env_phase = PH_IDLE;
            env_level = '0;
        end
        res.level = env_level;
        res.ph    = env_phase;
        env_prev_gate = gate;
        env_prev_trig = trig;
    endtask

    // Driver: offer queued samples, with a drawn gap before each one
    always @(posedge clk or negedge rst_n)
    begin
        env_t    nxt;
        sample_t s;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gate  <= 1'b0;
            in_trig  <= 1'b0;
            in_gap   <= 0;
        end
        else
        begin
            if (in_valid && in_ch.ready)
            begin
                advance_envelope(in_gate, in_trig, nxt);
                expected_env.push_back(nxt);
            end
            if (!in_valid || in_ch.ready)
            begin
                if (in_gap != 0)
                begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (sample_queue.size() != 0)
                begin
                    s = sample_queue.pop_front();
                    in_gate  <= s.gate;
                    in_trig  <= s.trig;
                    in_valid <= 1'b1;
                    in_gap   <= $urandom_range(0, in_gap_max);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each item and draw the stall before the next one
    always @(posedge clk or negedge rst_n)
    begin
        env_t want;
        int   w;
        if (!rst_n)
        begin
            out_ready      <= 1'b0;
            out_wait       <= 0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ready)
            begin
                if (expected_env.size() == 0)
                    report_mismatch("result arrived with nothing expected");
                else
                begin
                    want = expected_env.pop_front();
                    if (out_ch.level_out !== want.level)
                        report_mismatch($sformatf("level_out %0d, predicted %0d",
                                                  out_ch.level_out, want.level));
                    if (out_ch.phase_out !== want.ph)
                        report_mismatch($sformatf("phase_out %0d, predicted %0d",
                                                  out_ch.phase_out, want.ph));
                end
                results_seen++;
                if (results_seen >= HOLD_AT && !long_hold_done && sample_queue.size() > 8)
                begin
                    // Back up the block for a long stretch while samples keep coming
                    hold_left      <= LONG_HOLD;
                    long_hold_done <= 1'b1;
                    out_ready      <= 1'b0;
                end
                else
                begin
                    w = $urandom_range(0, out_gap_max);
                    out_wait  <= w;
                    out_ready <= (w == 0);
                end
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= (hold_left == 1);
            end
            else if (out_wait != 0)
            begin
                out_wait  <= out_wait - 1;
                out_ready <= (out_wait == 1);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ch.ready) || (out_ch.valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic push_sample(input logic g, input logic t);
        sample_t s;
        s.gate = g;
        s.trig = t;
        sample_queue.push_back(s);
        gen_gate = g;
        gen_trig = t;
        queued_items++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [STEP_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_ATTACK_STEP)
            cfg_attack_step = val;
        else if (idx == REG_DECAY_STEP)
            cfg_decay_step = val;
        else if (idx == REG_DECAY_FACTOR)
            cfg_decay_factor = val[STEP_W-2:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (sample_queue.size() != 0 || in_valid || expected_env.size() != 0);
    endtask

    function automatic int pick_pace();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            default: return 14;
        endcase
    endfunction

    // Drain, write all three registers, then pick the idling for this stretch
    task automatic begin_phase(input logic [STEP_W-1:0] att, input logic [STEP_W-1:0] dec,
                               input logic [STEP_W-1:0] fac);
        wait_drained();
        write_reg(REG_ATTACK_STEP, att);
        write_reg(REG_DECAY_STEP, dec);
        write_reg(REG_DECAY_FACTOR, fac);
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, STEP_W'($urandom_range(0, 32'(STEP_MAX))));
        @(negedge clk);
        in_gap_max  = pick_pace();
        out_gap_max = pick_pace();
    endtask

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(0, 11))
            0:       return ONE_STEP[STEP_W-1:0];
            1:       return STEP_MAX[STEP_W-1:0];
            2:       return '0;
            3:       return STEP_W'(1);
            4:       return STEP_W'($urandom_range(32'(ONE_STEP) / 2, 32'(ONE_STEP) - 1));
            5:       return STEP_W'($urandom_range(0, 32'(STEP_MAX)));
            default: return STEP_W'(ONE_STEP / 64'($urandom_range(2, 40)));
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] pick_factor();
        logic [STEP_W-2:0] f;
        case ($urandom_range(0, 5))
            0:       f = FACTOR_MAX[STEP_W-2:0];
            1:       f = '0;
            2:       f = (STEP_W-1)'($urandom_range(0, 32'(FACTOR_MAX)));
            default: f = (STEP_W-1)'(32'(ONE_STEP) - $urandom_range(1, 32'd1 << 20));
        endcase
        // Top bit lies outside the register and must be dropped
        return {1'($urandom_range(0, 1)), f};
    endfunction

    task automatic queue_pattern(input int count);
        int len;
        int stop;
        stop = queued_items + count;
        while (queued_items < stop)
        begin
            len = $urandom_range(1, 60);
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    push_sample(1'b0, gen_trig);
                    repeat (len) push_sample(1'b1, gen_trig);
                end
                4, 5, 6:
                begin
                    push_sample(gen_gate, 1'b0);
                    repeat ($urandom_range(1, 2)) push_sample(gen_gate, 1'b1);
                    repeat (len) push_sample(gen_gate, 1'b0);
                end
                7, 8:
                    repeat (len) push_sample(1'b0, 1'b0);
                default:
                    repeat ($urandom_range(1, 6))
                        push_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
        end
    endtask

    initial
    begin
        int target;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: both phases end on their first sample
        @(negedge clk);
        in_gap_max  = $urandom_range(0, 3);
        out_gap_max = $urandom_range(0, 3);
        push_sample(1'b0, 1'b0);
        push_sample(1'b1, 1'b0);
        push_sample(1'b1, 1'b0);
        push_sample(1'b1, 1'b1);
        push_sample(1'b0, 1'b1);
        push_sample(1'b0, 1'b0);
        push_sample(1'b0, 1'b1);

        // Quarter steps; retrigger mid ramp restarts from the level reached
        begin_phase(STEP_W'(ONE_STEP / 4), STEP_W'(ONE_STEP / 4), STEP_MAX[STEP_W-1:0]);
        write_reg(REG_UNUSED, STEP_W'($urandom_range(0, 32'(STEP_MAX))));
        push_sample(1'b1, 1'b0);
        push_sample(1'b1, 1'b0);
        push_sample(1'b1, 1'b1);
        repeat (10) push_sample(1'b1, 1'b1);

        // Zero attack step holds the start level
        begin_phase('0, STEP_MAX[STEP_W-1:0], '0);
        push_sample(1'b0, 1'b0);
        push_sample(1'b1, 1'b0);
        push_sample(1'b1, 1'b0);

        // Widest attack step, zero decay step keeps multiplying
        begin_phase(STEP_MAX[STEP_W-1:0], '0, FACTOR_MAX[STEP_W-1:0]);
        push_sample(1'b0, 1'b1);
        push_sample(1'b0, 1'b0);

        target = queued_items + RANDOM_ITEMS;
        while (queued_items < target)
        begin
            begin_phase(pick_step(), pick_step(), pick_factor());
            queue_pattern($urandom_range(100, 200));
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (expected_env.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      expected_env.size()));
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
